// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/ptss_pkg.sv -----
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types, constants and helpers of the periodic task slot scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ptss_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	// common width for comparing the 4-bit slot select against the fill count
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_SET   = 2'd2;
	localparam logic [1:0] REQ_SCAN  = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  slot_sel;
		logic        enable;
		logic [31:0] period;
	} req_t;

	typedef struct packed {
		logic [1:0]  resp_kind;
		logic [3:0]  slot_out;
		logic        ok;
		logic [31:0] tick_count;
		logic        last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_start;
		logic scan_step;
		logic scan_finish;
	} cmd_t;

	typedef struct packed {
		logic kind_scan;
		logic scan_idle;
	} sts_t;

	function automatic logic [3:0] to_slot(input logic [CMP_W-1:0] v);
		return v[3:0];
	endfunction

endpackage

`default_nettype wire

// ----- hdl/ptss_ram.sv -----
// ----------------------------------------------------------------------------
// ptss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/ptss_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptss_ctrl
// Request sequencer: accepts a request, runs it once or walks the slot table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptss_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ptss_pkg::sts_t sts,
	output      ptss_pkg::cmd_t cmd,
	output      logic           busy
);

	ptss_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptss_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		busy     = 1'b1;
		case (state_q)
			ptss_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_nx = ptss_pkg::ST_EXEC;
				end
			end
			ptss_pkg::ST_EXEC: begin
				if (sts.kind_scan) begin
					cmd.scan_start = 1'b1;
					state_nx       = ptss_pkg::ST_SCAN;
				end else begin
					cmd.exec = 1'b1;
					state_nx = ptss_pkg::ST_IDLE;
				end
			end
			ptss_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				// all reads issued and the last compare retired
				if (sts.scan_idle) begin
					state_nx = ptss_pkg::ST_FLUSH;
				end
			end
			ptss_pkg::ST_FLUSH: begin
				cmd.scan_finish = 1'b1;
				state_nx        = ptss_pkg::ST_IDLE;
			end
			default: begin
				state_nx = ptss_pkg::ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_accept_exec, state_q == ptss_pkg::ST_IDLE && start, state_q == ptss_pkg::ST_EXEC, "accepted transaction did not reach execute")
	`ASSERT_NEXT(a_flush_idle, state_q == ptss_pkg::ST_FLUSH, state_q == ptss_pkg::ST_IDLE, "scan flush did not return to idle")
	`ASSERT_IMPLIES(a_busy_load, cmd.load, !busy, "load issued while busy")

endmodule

`default_nettype wire

// ----- hdl/ptss_dp.sv -----
// ----------------------------------------------------------------------------
// ptss_dp
// Datapath: tick counter, slot table storage, due-time compare and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptss_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ptss_pkg::req_t req,
	input  wire ptss_pkg::cmd_t cmd,
	output      ptss_pkg::sts_t sts,
	output      ptss_pkg::rsp_t rsp,
	output      logic           rsp_valid
);

	localparam int IDX_W = ptss_pkg::IDX_W;
	localparam int CNT_W = ptss_pkg::CNT_W;
	localparam int CMP_W = ptss_pkg::CMP_W;

	ptss_pkg::req_t req_q;
	logic [31:0]               tick_q;
	// slots are never freed, so the allocated ones are exactly 0 .. cnt_q-1
	logic [CNT_W-1:0]          cnt_q;
	logic [ptss_pkg::SLOTS-1:0] enabled_q;
	logic [CNT_W-1:0]          idx_q;
	logic                      s1_valid_q;
	logic [IDX_W-1:0]          idx_s1_q;
	logic                      pend_valid_q;
	logic [IDX_W-1:0]          pend_slot_q;
	ptss_pkg::rsp_t            rsp_q;
	logic                      rsp_valid_q;

	logic [CMP_W-1:0] sel_ext;
	logic             alloc_ok;
	logic             set_ok;
	logic             issue;
	logic             fire;
	logic             emit;
	ptss_pkg::rsp_t   rsp_nx;

	logic             due_we;
	logic [IDX_W-1:0] due_waddr;
	logic [31:0]      due_wdata;
	logic [31:0]      due_rd;
	logic             per_we;
	logic [31:0]      per_rd;

	assign sel_ext  = CMP_W'(req_q.slot_sel);
	assign alloc_ok = cnt_q < CNT_W'(ptss_pkg::SLOTS);
	assign set_ok   = sel_ext < CMP_W'(cnt_q);
	assign issue    = cmd.scan_step && (idx_q < cnt_q);
	assign fire     = s1_valid_q && enabled_q[idx_s1_q] && (due_rd < tick_q);

	assign sts.kind_scan = req_q.req_type == ptss_pkg::REQ_SCAN;
	assign sts.scan_idle = !(idx_q < cnt_q) && !s1_valid_q;

	// due-time write port: allocation stamps the count, a firing slot advances
	always_comb begin
		due_we    = 1'b0;
		due_waddr = idx_s1_q;
		due_wdata = due_rd + per_rd;
		if (cmd.exec && req_q.req_type == ptss_pkg::REQ_ALLOC && alloc_ok) begin
			due_we    = 1'b1;
			due_waddr = cnt_q[IDX_W-1:0];
			due_wdata = tick_q;
		end else if (fire) begin
			due_we = 1'b1;
		end
	end

	assign per_we = cmd.exec && req_q.req_type == ptss_pkg::REQ_SET && set_ok;

	ptss_ram #(
		.WIDTH(32),
		.DEPTH(ptss_pkg::SLOTS)
	) u_due_ram (
		.clk  (clk),
		.we   (due_we),
		.waddr(due_waddr),
		.wdata(due_wdata),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(due_rd)
	);

	ptss_ram #(
		.WIDTH(32),
		.DEPTH(ptss_pkg::SLOTS)
	) u_per_ram (
		.clk  (clk),
		.we   (per_we),
		.waddr(sel_ext[IDX_W-1:0]),
		.wdata(req_q.period),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(per_rd)
	);

	// A fired slot is held back one step: only the next fire or the end of the
	// walk tells whether it is the final result of the scan.
	always_comb begin
		emit   = 1'b0;
		rsp_nx = '{resp_kind: req_q.req_type, slot_out: 4'd0, ok: 1'b0,
			tick_count: tick_q, last: 1'b1};
		if (cmd.exec) begin
			emit = 1'b1;
			case (req_q.req_type)
				ptss_pkg::REQ_TICK: begin
					rsp_nx.tick_count = tick_q + 32'd1;
				end
				ptss_pkg::REQ_ALLOC: begin
					if (alloc_ok) begin
						rsp_nx.slot_out = ptss_pkg::to_slot(CMP_W'(cnt_q));
						rsp_nx.ok       = 1'b1;
					end
				end
				ptss_pkg::REQ_SET: begin
					rsp_nx.slot_out = req_q.slot_sel;
					rsp_nx.ok       = set_ok;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end else if (fire && pend_valid_q) begin
			emit            = 1'b1;
			rsp_nx.slot_out = ptss_pkg::to_slot(CMP_W'(pend_slot_q));
			rsp_nx.ok       = 1'b1;
			rsp_nx.last     = 1'b0;
		end else if (cmd.scan_finish) begin
			emit = 1'b1;
			if (pend_valid_q) begin
				rsp_nx.slot_out = ptss_pkg::to_slot(CMP_W'(pend_slot_q));
				rsp_nx.ok       = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			cnt_q        <= '0;
			enabled_q    <= '0;
			idx_q        <= '0;
			s1_valid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rsp_valid_q <= emit;
			s1_valid_q  <= issue;
			if (cmd.exec && req_q.req_type == ptss_pkg::REQ_TICK) begin
				tick_q <= tick_q + 32'd1;
			end
			if (cmd.exec && req_q.req_type == ptss_pkg::REQ_ALLOC && alloc_ok) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			for (int i = 0; i < ptss_pkg::SLOTS; i++) begin
				if (per_we && sel_ext == CMP_W'(i)) begin
					enabled_q[i] <= req_q.enable;
				end
			end
			if (cmd.scan_start) begin
				idx_q        <= '0;
				pend_valid_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (fire) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.scan_finish) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		idx_s1_q <= idx_q[IDX_W-1:0];
		if (fire) begin
			pend_slot_q <= idx_s1_q;
		end
		if (emit) begin
			rsp_q <= rsp_nx;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	`ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_W'(ptss_pkg::SLOTS), "fill count beyond slot table")
	`ASSERT_IMPLIES(a_s1_alloc, s1_valid_q, CNT_W'(idx_s1_q) < cnt_q, "scan compare on a free slot")
	`ASSERT_IMPLIES(a_finish_drained, cmd.scan_finish, !s1_valid_q && !due_we, "scan closed with a compare in flight")

endmodule

`default_nettype wire

// ----- hdl/periodic_task_slot_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler
// Tick-driven task slot table: tick, allocate, set and scan requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Tick, allocate and
// set keep busy high for one cycle, and no other request is taken before
// busy is low again; their single result strobes in the cycle right after
// that busy cycle. A scan keeps busy high while it decodes the request, reads
// each allocated slot, retires the last compare, checks for the drain and
// closes the walk; an empty table has no slot read and no last compare. The
// walk reads one slot per cycle through the single read port of the due-time
// and period RAMs. A fired slot is reported when the next slot fires or
// when the walk closes; the final scan result strobes once busy is low again.
// Results appear on rsp for exactly one cycle each, flagged by rsp_valid, and
// cannot be held off by the receiver; the final result of every request
// carries last.
`default_nettype none

module periodic_task_slot_scheduler (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output      logic           busy,
	input  wire ptss_pkg::req_t req,
	output      ptss_pkg::rsp_t rsp,
	output      logic           rsp_valid
);

	ptss_pkg::cmd_t cmd;
	ptss_pkg::sts_t sts;

	ptss_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	ptss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp),
		.rsp_valid(rsp_valid)
	);

endmodule

`default_nettype wire

// ----- verif/ptss_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptss_checker
// Tracks the slot table of the scheduler from accepted requests, forecasts the
// result transactions of each one and compares them, in order and field by
// field, with the strobed results of the block.
// ----------------------------------------------------------------------------

module ptss_checker
	import ptss_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire req_t req,
	input  wire rsp_t rsp,
	input  wire logic rsp_valid,
	output int        fail_count,
	output int        pending,
	output int        results_seen,
	output int        fires_seen,
	output int        widest_scan
);

	logic [31:0] ticks;
	logic        taken   [SLOTS];
	logic        armed   [SLOTS];
	logic [31:0] per_tbl [SLOTS];
	logic [31:0] due_tbl [SLOTS];
	rsp_t        pending_rsps[$];

	function automatic rsp_t mk_rsp(input logic [1:0] kind, input logic [3:0] slot,
			input logic ok, input logic last);
		rsp_t r;
		r.resp_kind  = kind;
		r.slot_out   = slot;
		r.ok         = ok;
		r.tick_count = ticks;
		r.last       = last;
		return r;
	endfunction

	task automatic apply_request(input req_t r);
		logic [SLOTS-1:0] fired;
		int               last_idx;
		int               n;
		bit               found;
		fired    = '0;
		last_idx = 0;
		n        = 0;
		found    = 1'b0;
		case (r.req_type)
			REQ_TICK: begin
				ticks = ticks + 32'd1;
				pending_rsps.push_back(mk_rsp(REQ_TICK, 4'd0, 1'b0, 1'b1));
			end
			REQ_ALLOC: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && !taken[i]) begin
						found      = 1'b1;
						taken[i]   = 1'b1;
						due_tbl[i] = ticks;
						pending_rsps.push_back(mk_rsp(REQ_ALLOC, 4'(i), 1'b1, 1'b1));
					end
				end
				if (!found)
					pending_rsps.push_back(mk_rsp(REQ_ALLOC, 4'd0, 1'b0, 1'b1));
			end
			REQ_SET: begin
				if (int'(r.slot_sel) < SLOTS && taken[r.slot_sel]) begin
					armed[r.slot_sel]   = r.enable;
					per_tbl[r.slot_sel] = r.period;
					pending_rsps.push_back(mk_rsp(REQ_SET, r.slot_sel, 1'b1, 1'b1));
				end else begin
					pending_rsps.push_back(mk_rsp(REQ_SET, r.slot_sel, 1'b0, 1'b1));
				end
			end
			default: begin
				// due compare is plain unsigned; due time wraps on advance
				for (int i = 0; i < SLOTS; i++) begin
					if (taken[i] && armed[i] && due_tbl[i] < ticks) begin
						due_tbl[i] = due_tbl[i] + per_tbl[i];
						fired[i]   = 1'b1;
						last_idx   = i;
						n++;
					end
				end
				if (n == 0) begin
					pending_rsps.push_back(mk_rsp(REQ_SCAN, 4'd0, 1'b0, 1'b1));
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (fired[i])
							pending_rsps.push_back(mk_rsp(REQ_SCAN, 4'(i), 1'b1,
								i == last_idx));
				end
				fires_seen += n;
				if (n > widest_scan)
					widest_scan = n;
			end
		endcase
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t exp;
		if (pending_rsps.size() == 0) begin
			if (fail_count < 10)
				$display("%0t: unexpected result kind=%0d slot=%0d ok=%0d cnt=%0d last=%0d",
					$realtime, got.resp_kind, got.slot_out, got.ok, got.tick_count, got.last);
			fail_count++;
		end else begin
			exp = pending_rsps.pop_front();
			results_seen++;
			if (got.resp_kind !== exp.resp_kind || got.slot_out !== exp.slot_out ||
					got.ok !== exp.ok || got.tick_count !== exp.tick_count ||
					got.last !== exp.last) begin
				if (fail_count < 10) begin
					$display("%0t: result mismatch", $realtime);
					$display("  exp kind=%0d slot=%0d ok=%0d cnt=%0d last=%0d",
						exp.resp_kind, exp.slot_out, exp.ok, exp.tick_count, exp.last);
					$display("  got kind=%0d slot=%0d ok=%0d cnt=%0d last=%0d",
						got.resp_kind, got.slot_out, got.ok, got.tick_count, got.last);
				end
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks = '0;
			for (int i = 0; i < SLOTS; i++) begin
				taken[i]   = 1'b0;
				armed[i]   = 1'b0;
				per_tbl[i] = '0;
				due_tbl[i] = '0;
			end
			pending_rsps.delete();
			fail_count   = 0;
			pending      = 0;
			results_seen = 0;
			fires_seen   = 0;
			widest_scan  = 0;
		end else begin
			// forecast first: a result never precedes its own request
			if (start && !busy)
				apply_request(req);
			if (rsp_valid)
				check_result(rsp);
			pending = pending_rsps.size();
		end
	end

endmodule

// ----- verif/periodic_task_slot_scheduler_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_tb
// Drives tick, allocate, set and scan requests into the slot scheduler: a
// directed opening over the corner cases, then random traffic with idle gaps
// on the request side. Checking is done by ptss_checker.
// ----------------------------------------------------------------------------

module periodic_task_slot_scheduler_tb;
	import ptss_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 40;
	localparam int RANDOM_ITEMS   = 225;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	rsp_t rsp;
	logic rsp_valid;

	int fail_count;
	int pending;
	int results_seen;
	int fires_seen;
	int widest_scan;
	int issued = 0;
	int quiet_cycles = 0;

	periodic_task_slot_scheduler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

	ptss_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.rsp          (rsp),
		.rsp_valid    (rsp_valid),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.fires_seen   (fires_seen),
		.widest_scan  (widest_scan)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// no transaction in either direction for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || rsp_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no activity for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic req_t mk_req(input logic [1:0] kind, input logic [3:0] sel,
			input logic en, input logic [31:0] per);
		req_t r;
		r.req_type = kind;
		r.slot_sel = sel;
		r.enable   = en;
		r.period   = per;
		return r;
	endfunction

	function automatic logic [31:0] pick_period();
		int p;
		p = $urandom_range(9);
		if (p <= 5)
			return 32'($urandom_range(0, 6));
		else if (p <= 7)
			return $urandom;
		else if (p == 8)
			return 32'hFFFF_FFFF;
		else
			return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int   roll;
		// unused fields carry random junk
		r    = mk_req(REQ_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)), $urandom);
		roll = $urandom_range(99);
		if (roll < 35) begin
			r.req_type = REQ_TICK;
		end else if (roll < 40) begin
			r.req_type = REQ_ALLOC;
		end else if (roll < 72) begin
			r.req_type = REQ_SET;
			r.enable   = ($urandom_range(3) != 0);
			r.period   = pick_period();
		end else begin
			r.req_type = REQ_SCAN;
		end
		return r;
	endfunction

	// holds start until the transaction is taken; optional idle gap ahead of it
	task automatic issue(input req_t r, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(99) < 26) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		issued++;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		issue(mk_req(REQ_TICK, 4'd0, 1'b0, 32'd0), 1'b1);
		issue(mk_req(REQ_SCAN, 4'd0, 1'b0, 32'd0), 1'b1);          // empty table
		issue(mk_req(REQ_SET, 4'd3, 1'b1, 32'd5), 1'b1);           // slot still free
		for (int i = 0; i < SLOTS; i++)
			issue(mk_req(REQ_ALLOC, 4'd15, 1'b1, 32'hFFFF_FFFF), 1'b1);
		issue(mk_req(REQ_ALLOC, 4'd0, 1'b0, 32'd0), 1'b1);         // table full
		issue(mk_req(REQ_SET, 4'd0, 1'b1, 32'd0), 1'b1);
		issue(mk_req(REQ_SET, 4'd15, 1'b1, 32'hFFFF_FFFF), 1'b1);
		issue(mk_req(REQ_SCAN, 4'd0, 1'b0, 32'd0), 1'b1);          // due equals count
		issue(mk_req(REQ_TICK, 4'd15, 1'b1, 32'hFFFF_FFFF), 1'b1);
		issue(mk_req(REQ_SCAN, 4'd15, 1'b1, 32'hFFFF_FFFF), 1'b1);
		issue(mk_req(REQ_SCAN, 4'd0, 1'b0, 32'd0), 1'b1);          // due wrapped
		issue(mk_req(REQ_SET, 4'd15, 1'b0, 32'd1), 1'b1);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == 100) begin
				// arm every slot with a short period, then tick and scan the whole table
				for (int i = 0; i < SLOTS; i++)
					issue(mk_req(REQ_SET, 4'(i), 1'b1, 32'($urandom_range(0, 2))), 1'b1);
				issue(mk_req(REQ_TICK, 4'd0, 1'b0, 32'd0), 1'b1);
				issue(mk_req(REQ_SCAN, 4'd0, 1'b0, 32'd0), 1'b1);
			end
			issue(rand_req(), !(k >= 140 && k < 200));
		end
		start <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d results checked", issued, results_seen);
		$display("%0d slot firings, up to %0d in a single scan", fires_seen, widest_scan);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ptss_pkg.sv
hdl/ptss_ram.sv
hdl/ptss_ctrl.sv
hdl/ptss_dp.sv
hdl/periodic_task_slot_scheduler.sv
verif/ptss_checker.sv
verif/periodic_task_slot_scheduler_tb.sv
